// ===== design/dtwf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtwf_pkg
// Shared types and constants of the densest time window finder.
// ----------------------------------------------------------------------------
package dtwf_pkg;

  localparam int TIME_W = 48;
  localparam int NODE_W = 10;
  localparam int TYPE_W = 16;
  localparam int CNT_OUT_W = 11;
  localparam int IDX_OUT_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPAN = 3'd0,
    CFG_MIN_DISTINCT = 3'd1,
    CFG_REQ_A = 3'd2,
    CFG_REQ_B = 3'd3,
    CFG_REP_A = 3'd4,
    CFG_REP_B = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_BEST = 2'd0,
    KIND_TIE = 2'd1,
    KIND_NONE = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic head_rd;
    logic clr_ovf;
    logic judge;
    logic final_j;
    logic ev_rd;
    logic ev_wr;
    logic set_ovf;
    logic ins;
    logic inc;
    logic run_clear;
  } dtwf_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic occ_zero;
    logic over_span;
    logic full;
    logic room;
    logic item_last;
  } dtwf_stat_t;

endpackage

// ===== design/dtwf_if.sv =====
// ----------------------------------------------------------------------------
// dtwf_if
// Valid/ready channels for message words and result words.
// ----------------------------------------------------------------------------
interface dtwf_in_if import dtwf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] msg_time;
  logic [NODE_W-1:0] source_id;
  logic [NODE_W-1:0] dest_id;
  logic [TYPE_W-1:0] msg_type;
  logic              end_of_trace;

  modport source(output valid, msg_time, source_id, dest_id, msg_type, end_of_trace,
                 input ready);
  modport sink(input valid, msg_time, source_id, dest_id, msg_type, end_of_trace,
               output ready);
endinterface

interface dtwf_out_if import dtwf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_kind;
  logic [IDX_OUT_W-1:0] window_start;
  logic [IDX_OUT_W-1:0] window_end;
  logic [CNT_OUT_W-1:0] message_sum;
  logic [CNT_OUT_W-1:0] distinct_count;
  logic                 window_overflow;
  logic                 last_result;

  modport source(output valid, result_kind, window_start, window_end, message_sum,
                 distinct_count, window_overflow, last_result, input ready);
  modport sink(input valid, result_kind, window_start, window_end, message_sum,
               distinct_count, window_overflow, last_result, output ready);
endinterface

// ===== design/densest_time_window_finder.sv =====
// ----------------------------------------------------------------------------
// densest_time_window_finder
// Finds the time windows with the most counted messages and enough initiators.
// ----------------------------------------------------------------------------
// Messages arrive in time order on in_ch, one word per handshake. Each is kept
// in a ring of WINDOW_DEPTH entries; requests count their source and replies
// their destination as initiator, and a per-initiator occurrence table gives
// the distinct count. When a message would stretch the window past
// max_span_ticks, the window as it stands is judged and, if it is a new best
// or a tie, reported on out_ch, then the oldest entries are evicted. A message
// with end_of_trace set forces a final judgement (kind 2 if it is neither
// best nor tie); the window is then drained and numbering restarts at zero.
// After a word is accepted the sequencer reads the ring head, checks the
// span, inserts the entry and counts it in the occurrence table before the
// next word is taken; each entry evicted on span, each judgement and each
// entry forced out of a full ring add steps. A judgement also waits while
// the result register still holds an untaken word. Each eviction, one step
// at a time, re-reads the ring head and does a read-modify-write of the
// occurrence table; a run's end evicts every entry still held. After reset
// the occupancy table is cleared before any word is taken; configuration writes are
// taken at any time and must only be made while the block is idle.
// At most two result words follow from one message; the output register lets
// the block carry on while a result waits to be taken.
// ----------------------------------------------------------------------------
module densest_time_window_finder import dtwf_pkg::*; #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int ID_COUNT = 1024,
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  dtwf_in_if.sink               in_ch,
  dtwf_out_if.source            out_ch
);

  dtwf_cmd_t  cmd;
  dtwf_stat_t stat;

  // sequencer: hold the input until the previous word is fully processed
  dtwf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window store, counters and the result register
  dtwf_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .ID_COUNT     (ID_COUNT),
    .INDEX_BITS   (INDEX_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_msg_time         (in_ch.msg_time),
    .in_source_id        (in_ch.source_id),
    .in_dest_id          (in_ch.dest_id),
    .in_msg_type         (in_ch.msg_type),
    .in_end_of_trace     (in_ch.end_of_trace),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_result_kind     (out_ch.result_kind),
    .out_window_start    (out_ch.window_start),
    .out_window_end      (out_ch.window_end),
    .out_message_sum     (out_ch.message_sum),
    .out_distinct_count  (out_ch.distinct_count),
    .out_window_overflow (out_ch.window_overflow),
    .out_last_result     (out_ch.last_result)
  );

endmodule

// ===== design/dtwf_ram.sv =====
// ----------------------------------------------------------------------------
// dtwf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dtwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/dtwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtwf_ctrl
// Sequencer: clearing pass, span check, judgement, eviction, insertion, drain.
// ----------------------------------------------------------------------------
module dtwf_ctrl import dtwf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dtwf_stat_t stat,
  output dtwf_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_HEAD  = 11'b000_0000_0100,
    S_SPAN  = 11'b000_0000_1000,
    S_JUDGE = 11'b000_0001_0000,
    S_EV_RD = 11'b000_0010_0000,
    S_EV_WR = 11'b000_0100_0000,
    S_INS   = 11'b000_1000_0000,
    S_INC   = 11'b001_0000_0000,
    S_FINAL = 11'b010_0000_0000,
    S_DRAIN = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   judged_r, judged_nxt;
  logic   drain_r, drain_nxt;
  logic   force_r, force_nxt;

  always_comb begin
    state_nxt  = state_r;
    judged_nxt = judged_r;
    drain_nxt  = drain_r;
    force_nxt  = force_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          judged_nxt  = 1'b0;
          state_nxt   = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_SPAN;
      end
      S_SPAN: begin
        if (stat.over_span) begin
          state_nxt = judged_r ? S_EV_RD : S_JUDGE;
        end else begin
          cmd.clr_ovf = judged_r && stat.occ_zero;
          if (stat.full) begin
            force_nxt = 1'b1;
            state_nxt = S_EV_RD;
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_JUDGE: begin
        if (stat.room) begin
          cmd.judge  = 1'b1;
          judged_nxt = 1'b1;
          state_nxt  = S_SPAN;
        end
      end
      S_EV_RD: begin
        cmd.ev_rd = 1'b1;
        state_nxt = S_EV_WR;
      end
      S_EV_WR: begin
        cmd.ev_wr = 1'b1;
        if (force_r) begin
          cmd.set_ovf = 1'b1;
          force_nxt   = 1'b0;
          state_nxt   = S_INS;
        end else if (drain_r) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_INC;
      end
      S_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = stat.item_last ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        if (stat.room) begin
          cmd.judge   = 1'b1;
          cmd.final_j = 1'b1;
          drain_nxt   = 1'b1;
          state_nxt   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.occ_zero) begin
          cmd.run_clear = 1'b1;
          drain_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_EV_RD;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      judged_r <= 1'b0;
      drain_r  <= 1'b0;
      force_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      judged_r <= judged_nxt;
      drain_r  <= drain_nxt;
      force_r  <= force_nxt;
    end
  end

endmodule

// ===== design/dtwf_dp.sv =====
// ----------------------------------------------------------------------------
// dtwf_dp
// Datapath: message ring, occurrence table, window counters, result register.
// ----------------------------------------------------------------------------
module dtwf_dp import dtwf_pkg::*; #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int ID_COUNT = 1024,
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [TIME_W-1:0]     in_msg_time,
  input  logic [NODE_W-1:0]     in_source_id,
  input  logic [NODE_W-1:0]     in_dest_id,
  input  logic [TYPE_W-1:0]     in_msg_type,
  input  logic                  in_end_of_trace,
  input  dtwf_cmd_t             cmd,
  output dtwf_stat_t            stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_result_kind,
  output logic [IDX_OUT_W-1:0]  out_window_start,
  output logic [IDX_OUT_W-1:0]  out_window_end,
  output logic [CNT_OUT_W-1:0]  out_message_sum,
  output logic [CNT_OUT_W-1:0]  out_distinct_count,
  output logic                  out_window_overflow,
  output logic                  out_last_result
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int ID_W = $clog2(ID_COUNT);
  localparam int SAT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int RING_W = TIME_W + ID_W + 1;

  function automatic logic [ID_W-1:0] id_mod(input logic [NODE_W-1:0] node);
    logic [31:0] v;
    v = 32'(node);
    for (int k = NODE_W - 1; k >= 0; k--) begin
      if (v >= (32'(ID_COUNT) << k)) begin
        v = v - (32'(ID_COUNT) << k);
      end
    end
    return ID_W'(v);
  endfunction

  function automatic logic [CNT_OUT_W-1:0] sat_cnt(input logic [CNT_W-1:0] c);
    logic [SAT_W-1:0] e;
    e = SAT_W'(c);
    return (e > SAT_W'(2047)) ? {CNT_OUT_W{1'b1}} : e[CNT_OUT_W-1:0];
  endfunction

  // configuration
  logic [TIME_W-1:0]    max_span_r;
  logic [CNT_OUT_W-1:0] min_distinct_r;
  logic [TYPE_W-1:0]    req_a_r, req_b_r, rep_a_r, rep_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_span_r     <= '0;
      min_distinct_r <= CNT_OUT_W'(1);
      req_a_r        <= '0;
      req_b_r        <= '0;
      rep_a_r        <= '0;
      rep_b_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MAX_SPAN:     max_span_r     <= cfg_wdata[TIME_W-1:0];
        CFG_MIN_DISTINCT: min_distinct_r <= cfg_wdata[CNT_OUT_W-1:0];
        CFG_REQ_A:        req_a_r        <= cfg_wdata[TYPE_W-1:0];
        CFG_REQ_B:        req_b_r        <= cfg_wdata[TYPE_W-1:0];
        CFG_REP_A:        rep_a_r        <= cfg_wdata[TYPE_W-1:0];
        CFG_REP_B:        rep_b_r        <= cfg_wdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // captured message
  logic [TIME_W-1:0] t_r;
  logic [ID_W-1:0]   id_r;
  logic              counted_r;
  logic              last_r;
  logic              is_req, is_rep;

  assign is_req = (in_msg_type == req_a_r) || (in_msg_type == req_b_r);
  assign is_rep = (in_msg_type == rep_a_r) || (in_msg_type == rep_b_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r       <= in_msg_time;
      counted_r <= is_req || is_rep;
      last_r    <= in_end_of_trace;
      if (is_req) begin
        id_r <= id_mod(in_source_id);
      end else if (is_rep) begin
        id_r <= id_mod(in_dest_id);
      end else begin
        id_r <= '0;
      end
    end
  end

  // window control state
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [INDEX_BITS-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [CNT_W-1:0]      sum_r, sum_nxt, distinct_r, distinct_nxt, best_r, best_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [ID_W-1:0]       clr_cnt_r, clr_cnt_nxt;

  // ring and occurrence table
  logic [RING_W-1:0] ring_q;
  logic [TIME_W-1:0] old_time;
  logic [ID_W-1:0]   old_id;
  logic              old_counted;
  logic [PTR_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  occ_q;
  logic              tab_we, tab_re;
  logic [ID_W-1:0]   tab_addr;
  logic [CNT_W-1:0]  tab_wdata;

  assign {old_time, old_id, old_counted} = ring_q;
  assign tail_sum = (PTR_W+1)'(head_r) + (PTR_W+1)'(occ_r);
  assign tail = (tail_sum >= (PTR_W+1)'(WINDOW_DEPTH)) ?
                PTR_W'(tail_sum - (PTR_W+1)'(WINDOW_DEPTH)) : PTR_W'(tail_sum);

  dtwf_ram #(.WIDTH(RING_W), .DEPTH(WINDOW_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.ins),
    .waddr (tail),
    .wdata ({t_r, id_r, counted_r}),
    .re    (cmd.head_rd),
    .raddr (head_r),
    .rdata (ring_q)
  );

  always_comb begin
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    tab_addr  = id_r;
    tab_wdata = '0;
    if (cmd.clr_step) begin
      tab_we   = 1'b1;
      tab_addr = clr_cnt_r;
    end else if (cmd.ev_rd) begin
      tab_re   = old_counted;
      tab_addr = old_id;
    end else if (cmd.ev_wr) begin
      tab_we    = old_counted && (occ_q != '0);
      tab_addr  = old_id;
      tab_wdata = occ_q - CNT_W'(1);
    end else if (cmd.ins) begin
      tab_re = counted_r;
    end else if (cmd.inc) begin
      tab_we    = counted_r;
      tab_wdata = occ_q + CNT_W'(1);
    end
  end

  dtwf_ram #(.WIDTH(CNT_W), .DEPTH(ID_COUNT)) u_occ (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_addr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_addr),
    .rdata (occ_q)
  );

  // span against the oldest entry; time running backwards gives zero
  logic [TIME_W-1:0] span;
  assign span = (t_r >= old_time) ? (t_r - old_time) : '0;

  // judgement
  logic [SAT_W-1:0] dist_ext, min_ext;
  logic             qual, gt, eq, emit_now;
  result_kind_t     kind;

  assign dist_ext = SAT_W'(distinct_r);
  assign min_ext  = SAT_W'(min_distinct_r);
  assign qual     = dist_ext >= min_ext;
  assign gt       = sum_r > best_r;
  assign eq       = sum_r == best_r;
  assign emit_now = cmd.judge && (cmd.final_j || (qual && (gt || eq)));
  assign kind     = (qual && gt) ? KIND_BEST : ((qual && eq) ? KIND_TIE : KIND_NONE);

  always_comb begin
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    sum_nxt      = sum_r;
    distinct_nxt = distinct_r;
    best_nxt     = best_r;
    ovf_nxt      = ovf_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + ID_W'(1);
    end
    if (cmd.judge && qual && gt) begin
      best_nxt = sum_r;
    end
    if (cmd.clr_ovf) begin
      ovf_nxt = 1'b0;
    end
    if (cmd.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.ev_wr) begin
      if (old_counted) begin
        if (occ_q == CNT_W'(1) && distinct_r != '0) begin
          distinct_nxt = distinct_r - CNT_W'(1);
        end
        if (sum_r != '0) begin
          sum_nxt = sum_r - CNT_W'(1);
        end
      end
      head_nxt = (head_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      occ_nxt  = occ_r - CNT_W'(1);
      low_nxt  = low_r + INDEX_BITS'(1);
    end
    if (cmd.inc) begin
      if (counted_r) begin
        if (occ_q == '0) begin
          distinct_nxt = distinct_r + CNT_W'(1);
        end
        sum_nxt = sum_r + CNT_W'(1);
      end
      occ_nxt  = occ_r + CNT_W'(1);
      high_nxt = high_r + INDEX_BITS'(1);
    end
    if (cmd.run_clear) begin
      head_nxt     = '0;
      occ_nxt      = '0;
      low_nxt      = '0;
      high_nxt     = '0;
      sum_nxt      = '0;
      distinct_nxt = '0;
      best_nxt     = '0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      occ_r      <= '0;
      low_r      <= '0;
      high_r     <= '0;
      sum_r      <= '0;
      distinct_r <= '0;
      best_r     <= '0;
      ovf_r      <= 1'b0;
      clr_cnt_r  <= '0;
    end else begin
      head_r     <= head_nxt;
      occ_r      <= occ_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      sum_r      <= sum_nxt;
      distinct_r <= distinct_nxt;
      best_r     <= best_nxt;
      ovf_r      <= ovf_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // result register
  logic                  out_valid_r;
  logic [31:0]           low_ext, end_ext;
  logic [INDEX_BITS-1:0] last_idx;

  assign last_idx = high_r - INDEX_BITS'(1);
  assign low_ext  = 32'(low_r);
  assign end_ext  = 32'(last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_result_kind     <= kind;
      out_window_start    <= low_ext[IDX_OUT_W-1:0];
      out_window_end      <= end_ext[IDX_OUT_W-1:0];
      out_message_sum     <= sat_cnt(sum_r);
      out_distinct_count  <= sat_cnt(distinct_r);
      out_window_overflow <= ovf_r;
      out_last_result     <= cmd.final_j;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.clr_done  = clr_cnt_r == ID_W'(ID_COUNT - 1);
  assign stat.occ_zero  = occ_r == '0;
  assign stat.over_span = (occ_r != '0) && (span > max_span_r);
  assign stat.full      = occ_r == CNT_W'(WINDOW_DEPTH);
  assign stat.room      = !out_valid_r || out_ready;
  assign stat.item_last = last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(WINDOW_DEPTH))
    else $error("ring occupancy beyond depth");

  a_distinct_le_sum: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= sum_r)
    else $error("distinct initiators exceed counted messages");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit_now |-> (!out_valid_r || out_ready))
    else $error("result word overwritten before taken");

  a_best_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.judge && qual && gt && !cmd.final_j) |=> (best_r == $past(sum_r)))
    else $error("best sum not updated on new best");

endmodule
